/* rtl/cylinder_trigger_box_query_assert.svh */
// Assertion macros used by the checker file.
`ifndef CYLINDER_TRIGGER_BOX_QUERY_ASSERT_SVH
`define CYLINDER_TRIGGER_BOX_QUERY_ASSERT_SVH

// Clocked assertion, disabled while reset is high.
`define CTBQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CTBQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/ctbq_pkg.sv */
package ctbq_pkg;

   localparam int COORD_W    = 24;
   localparam int SIZE_W     = 23;
   localparam int KIND_W     = 8;
   localparam int TAG_W      = 16;

   localparam int OP_W       = 2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // stored box, first request field in the low bits
   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [KIND_W-1:0]  kind;
      logic [SIZE_W-1:0]  size_z;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_x;
      logic [COORD_W-1:0] center_z;
      logic [COORD_W-1:0] center_y;
      logic [COORD_W-1:0] center_x;
   } ctbq_box_type;

   localparam int BOX_W      = $bits(ctbq_box_type);
   localparam int RADIUS_LSB = BOX_W;
   localparam int HEIGHT_LSB = BOX_W + SIZE_W;
   localparam int REQ_BITS   = BOX_W + 2 * SIZE_W;
   localparam int REQ_DATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((BOX_W + 7) / 8) * 8;
   localparam int RSP_USER_W = 2;

   // Q.1 working widths
   localparam int QW    = 27;
   localparam int SQ_W  = 51;
   localparam int SUM_W = 52;
   localparam int RSQ_W = 48;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ctbq_state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic add;
      logic query;
      logic scan;
      logic load_out;
   } ctbq_cmd_type;

   typedef struct packed {
      logic hit;
      logic drained;
   } ctbq_status_type;

endpackage

/* rtl/ctbq_ram.sv */
module ctbq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/ctbq_ctrl.sv */
module ctbq_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [ctbq_pkg::OP_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output ctbq_pkg::ctbq_cmd_type        cmd,
   input  ctbq_pkg::ctbq_status_type     status
);

   import ctbq_pkg::*;

   ctbq_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_tuser == OP_QUERY) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            if (status.hit || status.drained) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
            unique case (req_tuser)
               OP_CLEAR: cmd.clear = req_tvalid;
               OP_ADD:   cmd.add   = req_tvalid;
               OP_QUERY: cmd.query = req_tvalid;
               default: ;
            endcase
         end
         ST_SCAN:   cmd.scan     = 1'b1;
         ST_FINISH: cmd.load_out = slot_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/ctbq_dp.sv */
module ctbq_dp #(
   parameter int MAX_BOXES = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctbq_pkg::ctbq_cmd_type              cmd,
   output ctbq_pkg::ctbq_status_type           status,
   input  logic [ctbq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic [ctbq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [ctbq_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   import ctbq_pkg::*;

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_BOXES);

   // control
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          rd_valid_ff, rd_valid_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s3_valid_ff, s3_valid_in;
   logic          issue, go, hit, drained, ypass, has_room;

   // query operands, Q.1 (radius square Q.2)
   logic signed [QW-1:0] bx_ff, bx_in, bz_ff, bz_in;
   logic signed [QW-1:0] bym_ff, bym_in, byh_ff, byh_in;
   logic signed [QW-1:0] by_q, h2_q;
   logic [RSQ_W-1:0]     rsq_ff, rsq_in;
   logic [SIZE_W:0]      r2_q;

   // scan pipeline
   ctbq_box_type         wr_box, rd_box;
   logic signed [QW-1:0] cx_q, cy_q, cz_q, hx_q, hy_q, hz_q;
   ctbq_box_type         s1_box_ff, s2_box_ff, s3_box_ff;
   logic signed [QW-1:0] s1_lox_ff, s1_lox_in, s1_hix_ff, s1_hix_in;
   logic signed [QW-1:0] s1_loz_ff, s1_loz_in, s1_hiz_ff, s1_hiz_in;
   logic signed [QW-1:0] s1_ytop_ff, s1_ytop_in, s1_ybot_ff, s1_ybot_in;
   logic signed [QW-1:0] s2_dx_ff, s2_dx_in, s2_dz_ff, s2_dz_in;
   logic signed [2*QW-1:0] sqx_full, sqz_full;
   logic [SQ_W-1:0]      s3_sqx_ff, s3_sqz_ff;
   logic [SUM_W-1:0]     dist_sum;

   // results
   logic                 pend_found_ff, pend_found_in, pend_full_ff, pend_full_in;
   ctbq_box_type         pend_box_ff, pend_box_in;
   logic                 out_found_ff, out_full_ff;
   ctbq_box_type         out_box_ff;

   assign wr_box   = req_tdata[BOX_W-1:0];
   assign has_room = count_ff < FULL_COUNT;

   ctbq_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_BOXES),
      .AW    (AW)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (cmd.add && has_room),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_box),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_box)
   );

   assign by_q = {{2{req_tdata[2*COORD_W-1]}}, req_tdata[2*COORD_W-1:COORD_W], 1'b0};
   assign h2_q = {3'b000, req_tdata[HEIGHT_LSB+SIZE_W-1:HEIGHT_LSB], 1'b0};
   assign r2_q = {req_tdata[RADIUS_LSB+SIZE_W-1:RADIUS_LSB], 1'b0};

   assign bx_in  = {{2{req_tdata[COORD_W-1]}}, req_tdata[COORD_W-1:0], 1'b0};
   assign bz_in  = {{2{req_tdata[3*COORD_W-1]}}, req_tdata[3*COORD_W-1:2*COORD_W], 1'b0};
   assign bym_in = by_q - h2_q;
   assign byh_in = by_q + h2_q;
   assign rsq_in = RSQ_W'(r2_q) * RSQ_W'(r2_q);

   // first box that survives the compare wins; later entries are dropped
   assign dist_sum = {1'b0, s3_sqx_ff} + {1'b0, s3_sqz_ff};
   assign hit      = cmd.scan && s3_valid_ff
                     && (dist_sum <= {{(SUM_W-RSQ_W){1'b0}}, rsq_ff});
   assign go       = cmd.scan && !hit;
   assign issue    = go && (scan_ff < count_ff);
   assign drained  = (scan_ff >= count_ff) && !rd_valid_ff && !s1_valid_ff
                     && !s2_valid_ff && !s3_valid_ff;

   assign status.hit     = hit;
   assign status.drained = drained;

   // stage 1: box bounds
   assign cx_q = {{2{rd_box.center_x[COORD_W-1]}}, rd_box.center_x, 1'b0};
   assign cy_q = {{2{rd_box.center_y[COORD_W-1]}}, rd_box.center_y, 1'b0};
   assign cz_q = {{2{rd_box.center_z[COORD_W-1]}}, rd_box.center_z, 1'b0};
   assign hx_q = {4'b0000, rd_box.size_x};
   assign hy_q = {4'b0000, rd_box.size_y};
   assign hz_q = {4'b0000, rd_box.size_z};

   assign s1_lox_in  = cx_q - hx_q;
   assign s1_hix_in  = cx_q + hx_q;
   assign s1_loz_in  = cz_q - hz_q;
   assign s1_hiz_in  = cz_q + hz_q;
   assign s1_ytop_in = cy_q + hy_q;
   assign s1_ybot_in = cy_q - hy_q;

   // stage 2: vertical test and clamp distance
   assign ypass = !(bym_ff > s1_ytop_ff) && !(byh_ff < s1_ybot_ff);

   always_comb begin
      if (bx_ff < s1_lox_ff) begin
         s2_dx_in = bx_ff - s1_lox_ff;
      end else if (bx_ff > s1_hix_ff) begin
         s2_dx_in = bx_ff - s1_hix_ff;
      end else begin
         s2_dx_in = '0;
      end
      if (bz_ff < s1_loz_ff) begin
         s2_dz_in = bz_ff - s1_loz_ff;
      end else if (bz_ff > s1_hiz_ff) begin
         s2_dz_in = bz_ff - s1_hiz_ff;
      end else begin
         s2_dz_in = '0;
      end
   end

   // stage 3: squares
   assign sqx_full = (2*QW)'(s2_dx_ff) * (2*QW)'(s2_dx_ff);
   assign sqz_full = (2*QW)'(s2_dz_ff) * (2*QW)'(s2_dz_ff);

   assign rd_valid_in = issue;
   assign s1_valid_in = rd_valid_ff && go;
   assign s2_valid_in = s1_valid_ff && go && ypass;
   assign s3_valid_in = s2_valid_ff && go;

   always_comb begin
      scan_in = scan_ff;
      if (cmd.query) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.add && has_room) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      pend_found_in = pend_found_ff;
      pend_full_in  = pend_full_ff;
      pend_box_in   = pend_box_ff;
      if (cmd.accept) begin
         pend_found_in = 1'b0;
         pend_full_in  = cmd.add && !has_room;
         pend_box_in   = '0;
      end else if (hit) begin
         pend_found_in = 1'b1;
         pend_box_in   = s3_box_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         scan_ff     <= '0;
         rd_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         scan_ff     <= scan_in;
         rd_valid_ff <= rd_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.query) begin
         bx_ff  <= bx_in;
         bz_ff  <= bz_in;
         bym_ff <= bym_in;
         byh_ff <= byh_in;
         rsq_ff <= rsq_in;
      end
      s1_box_ff  <= rd_box;
      s1_lox_ff  <= s1_lox_in;
      s1_hix_ff  <= s1_hix_in;
      s1_loz_ff  <= s1_loz_in;
      s1_hiz_ff  <= s1_hiz_in;
      s1_ytop_ff <= s1_ytop_in;
      s1_ybot_ff <= s1_ybot_in;
      s2_box_ff  <= s1_box_ff;
      s2_dx_ff   <= s2_dx_in;
      s2_dz_ff   <= s2_dz_in;
      s3_box_ff  <= s2_box_ff;
      s3_sqx_ff  <= sqx_full[SQ_W-1:0];
      s3_sqz_ff  <= sqz_full[SQ_W-1:0];
      pend_found_ff <= pend_found_in;
      pend_full_ff  <= pend_full_in;
      pend_box_ff   <= pend_box_in;
      if (cmd.load_out) begin
         out_found_ff <= pend_found_ff;
         out_full_ff  <= pend_full_ff;
         out_box_ff   <= pend_box_ff;
      end
   end

   assign rsp_tdata = {{(RSP_DATA_W-BOX_W){1'b0}}, out_box_ff};
   assign rsp_tuser = {out_full_ff, out_found_ff};

endmodule

/* rtl/cylinder_trigger_box_query.sv */
// Trigger box table with a cylinder overlap query. Items come in on req_ and
// one result per item goes out on rsp_; the operation code rides in req_tuser.
// A query walks the stored boxes in insertion order, one box RAM read per
// cycle, through a four-stage compare pipeline, and stops at the first
// overlapping box or after the last stored box. One more item is taken
// while a finished result still waits on rsp_. Boxes are kept with no
// reset; only entries written since the last clear are ever read.
module cylinder_trigger_box_query #(
   parameter int MAX_BOXES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x, point_y, point_z, extent_x, extent_y, extent_z, box_kind,
   // box_tag, cyl_radius, cyl_height
   input  logic [ctbq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation
   input  logic [ctbq_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit_center_x, hit_center_y, hit_center_z, hit_size_x, hit_size_y,
   // hit_size_z, hit_kind, hit_tag
   output logic [ctbq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found, table_full
   output logic [ctbq_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import ctbq_pkg::*;

   ctbq_cmd_type    cmd;
   ctbq_status_type status;

   ctbq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   ctbq_dp #(
      .MAX_BOXES (MAX_BOXES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

/* rtl/ctbq_checker.sv */
`include "cylinder_trigger_box_query_assert.svh"

module ctbq_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [ctbq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic [ctbq_pkg::OP_W-1:0]         req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ctbq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [ctbq_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   import ctbq_pkg::*;

   logic req_xfer;
   logic no_match;

   assign req_xfer = req_tvalid && req_tready;
   assign no_match = rsp_tvalid && !rsp_tuser[0];

   `CTBQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "rsp changed while stalled")
   `CTBQ_ASSERT(a_miss_zero, clock, reset, no_match |-> rsp_tdata == '0, "result without a match carries box data")
   `CTBQ_ASSERT(a_one_item, clock, reset, req_xfer |=> !req_tready, "second item taken while one is in work")
   `CTBQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "rsp valid right after reset")

endmodule

bind cylinder_trigger_box_query ctbq_checker u_ctbq_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;
   import ctbq_pkg::*;

   localparam int TABLE_DEPTH  = 64;
   localparam int DRAIN_CYCLES = TABLE_DEPTH + 24;
   localparam int PHASE_ITEMS  = 400;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef logic [REQ_DATA_W-1:0] req_word_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      ctbq_box_type      box;
      logic [SIZE_W-1:0] radius;
      logic [SIZE_W-1:0] height;
   } box_item_type;

   typedef struct {
      logic         found;
      logic         table_full;
      ctbq_box_type box;
   } hit_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;

   box_item_type   pending_items[$];
   hit_result_type expected_results[$];
   ctbq_box_type   placed_boxes[$];

   ctbq_box_type trigger_table[TABLE_DEPTH];
   int           stored_boxes   = 0;
   int           queued_items   = 0;
   int           accepted_items = 0;
   int           results_seen   = 0;
   int           errors         = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           hold_left      = 0;
   bit           hold_done      = 1'b0;
   box_item_type bus_item;

   cylinder_trigger_box_query #(
      .MAX_BOXES(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #(10_000_000);
      $display("RESULT: ERROR");
      $finish;
   end

   // Q.1 working domain: coordinates doubled, raw size is the half-size
   function automatic hit_result_type overlap_lookup(box_item_type it);
      hit_result_type res;
      longint bx, by, bz, rr, hh, rsq;
      longint cx, cy, cz, hx, hy, hz, dx, dz;
      res.found      = 1'b0;
      res.table_full = 1'b0;
      res.box        = '0;
      case (it.op)
         OP_CLEAR: stored_boxes = 0;
         OP_ADD: begin
            if (stored_boxes >= TABLE_DEPTH) begin
               res.table_full = 1'b1;
            end else begin
               trigger_table[stored_boxes] = it.box;
               stored_boxes++;
            end
         end
         OP_QUERY: begin
            bx  = 2 * longint'($signed(it.box.center_x));
            by  = 2 * longint'($signed(it.box.center_y));
            bz  = 2 * longint'($signed(it.box.center_z));
            rr  = 2 * longint'(it.radius);
            hh  = 2 * longint'(it.height);
            rsq = rr * rr;
            for (int i = 0; i < stored_boxes; i++) begin
               if (!res.found) begin
                  cy = 2 * longint'($signed(trigger_table[i].center_y));
                  hy = longint'(trigger_table[i].size_y);
                  if (by <= cy + hy + hh && by + hh >= cy - hy) begin
                     cx = 2 * longint'($signed(trigger_table[i].center_x));
                     cz = 2 * longint'($signed(trigger_table[i].center_z));
                     hx = longint'(trigger_table[i].size_x);
                     hz = longint'(trigger_table[i].size_z);
                     dx = (bx < cx - hx) ? bx - (cx - hx) :
                          (bx > cx + hx) ? bx - (cx + hx) : 0;
                     dz = (bz < cz - hz) ? bz - (cz - hz) :
                          (bz > cz + hz) ? bz - (cz + hz) : 0;
                     if (dx * dx + dz * dz <= rsq) begin
                        res.found = 1'b1;
                        res.box   = trigger_table[i];
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic box_item_type make_item(
      logic [OP_W-1:0] op,
      logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz,
      logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy, logic [SIZE_W-1:0] sz,
      logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
      logic [SIZE_W-1:0] radius, logic [SIZE_W-1:0] height);
      box_item_type it;
      it.op           = op;
      it.box.center_x = px;
      it.box.center_y = py;
      it.box.center_z = pz;
      it.box.size_x   = sx;
      it.box.size_y   = sy;
      it.box.size_z   = sz;
      it.box.kind     = kind;
      it.box.tag      = tag;
      it.radius       = radius;
      it.height       = height;
      return it;
   endfunction

   function automatic void push_item(box_item_type it);
      if (it.op == OP_CLEAR)
         placed_boxes.delete();
      else if (it.op == OP_ADD && placed_boxes.size() < TABLE_DEPTH)
         placed_boxes.push_back(it.box);
      pending_items.push_back(it);
      queued_items++;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      int v;
      if ($urandom_range(3) == 0)
         return COORD_W'($urandom);
      v = int'($urandom_range(16384)) - 8192;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] rand_extent();
      int sel;
      sel = $urandom_range(15);
      if (sel == 0)
         return '0;
      if (sel < 4)
         return SIZE_W'($urandom);
      return SIZE_W'($urandom_range(4096));
   endfunction

   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c,
                                                     logic [SIZE_W-1:0] s);
      int span;
      int off;
      span = (s > 23'd65536) ? 65536 : int'(s);
      span = span / 2 + 1024;
      off  = int'($urandom_range(2 * span)) - span;
      return c + off[COORD_W-1:0];
   endfunction

   // mostly adds and queries aimed at stored boxes, some clears and noise
   function automatic box_item_type random_item();
      box_item_type it;
      ctbq_box_type tgt;
      int           sel;
      it = make_item(OP_ADD, rand_coord(), rand_coord(), rand_coord(),
                     rand_extent(), rand_extent(), rand_extent(),
                     KIND_W'($urandom), TAG_W'($urandom),
                     rand_extent(), rand_extent());
      sel = $urandom_range(99);
      if (sel < 3)
         it.op = OP_CLEAR;
      else if (sel < 7)
         it.op = OP_UNUSED;
      else if (sel < 50)
         it.op = OP_ADD;
      else
         it.op = OP_QUERY;
      if (it.op == OP_QUERY && placed_boxes.size() > 0 && $urandom_range(9) < 7) begin
         tgt = placed_boxes[$urandom_range(placed_boxes.size() - 1)];
         it.box.center_x = near_coord(tgt.center_x, tgt.size_x);
         it.box.center_y = near_coord(tgt.center_y, tgt.size_y);
         it.box.center_z = near_coord(tgt.center_z, tgt.size_z);
         it.radius       = SIZE_W'($urandom_range(1536));
         it.height       = SIZE_W'($urandom_range(3072));
      end
      return it;
   endfunction

   task automatic wait_drained();
      while (accepted_items != queued_items || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, int count);
      box_item_type it;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            push_item(make_item(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
            for (int j = 0; j < TABLE_DEPTH + 3; j++) begin
               it    = random_item();
               it.op = OP_ADD;
               push_item(it);
            end
         end
         push_item(random_item());
      end
      wait_drained();
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(overlap_lookup(bus_item));
            accepted_items++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_item   = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= req_word_type'({bus_item.height, bus_item.radius,
                                             bus_item.box});
               req_tuser  <= bus_item.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, with one long hold-off to back the block up
   always @(posedge clock) begin : rsp_ready_gen
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      hit_result_type want;
      ctbq_box_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got = rsp_tdata[BOX_W-1:0];
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t unexpected transfer: expected none, actual tdata %h tuser %h",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = expected_results.pop_front();
            check_field("found", want.found, rsp_tuser[0]);
            check_field("table_full", want.table_full, rsp_tuser[1]);
            check_field("hit_center_x", want.box.center_x, got.center_x);
            check_field("hit_center_y", want.box.center_y, got.center_y);
            check_field("hit_center_z", want.box.center_z, got.center_z);
            check_field("hit_size_x", want.box.size_x, got.size_x);
            check_field("hit_size_y", want.box.size_y, got.size_y);
            check_field("hit_size_z", want.box.size_z, got.size_z);
            check_field("hit_kind", want.box.kind, got.kind);
            check_field("hit_tag", want.box.tag, got.tag);
            check_field("tdata pad", '0, rsp_tdata[RSP_DATA_W-1:BOX_W]);
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table, unused code, extreme boxes
      push_item(make_item(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, '1, '1));
      push_item(make_item(OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      push_item(make_item(OP_ADD, '0, '0, '0, '0, '0, '0, 8'hFF, 16'hFFFF, '1, '1));
      push_item(make_item(OP_ADD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                          '1, '1, '1, '0, '0, '0, '0));
      push_item(make_item(OP_ADD, 24'h800000, 24'h800000, 24'h800000,
                          '0, '0, '0, 8'h5A, 16'hA5A5, '0, '0));
      push_item(make_item(OP_ADD, '0, '0, '0, 23'd2, 23'd2, 23'd2, 8'h01, 16'h0001, '0, '0));
      // point box, radius zero
      push_item(make_item(OP_QUERY, '0, '0, '0, '1, '1, '1, '1, '1, '0, '0));
      // distance exactly equal to radius, then one short
      push_item(make_item(OP_QUERY, 24'd3, '0, '0, '0, '0, '0, '0, '0, 23'd3, '0));
      push_item(make_item(OP_QUERY, 24'd3, '0, '0, '0, '0, '0, '0, '0, 23'd2, '0));
      // cylinder top touching box bottom, then just below
      push_item(make_item(OP_QUERY, '0, 24'hFFFFFB, '0, '0, '0, '0, '0, '0, '0, 23'd5));
      push_item(make_item(OP_QUERY, '0, 24'hFFFFFB, '0, '0, '0, '0, '0, '0, '0, 23'd4));
      // base just above box top
      push_item(make_item(OP_QUERY, '0, 24'd1, '0, '0, '0, '0, '0, '0, '0, '0));
      push_item(make_item(OP_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                          '0, '0, '0, '0, '0, '0, '0));
      push_item(make_item(OP_QUERY, 24'h800000, 24'h800000, 24'h800000,
                          '0, '0, '0, '0, '0, '1, '1));
      push_item(make_item(OP_QUERY, 24'h800000, 24'h800000, 24'h800000,
                          '0, '0, '0, '0, '0, '0, '0));
      push_item(make_item(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
      push_item(make_item(OP_QUERY, '0, '0, '0, '0, '0, '0, '0, '0, '1, '1));
      push_item(make_item(OP_ADD, 24'h123456, 24'hABCDEF, 24'h00FF00,
                          23'h2AAAAA, 23'h555555, 23'h7F00FF, 8'hC3, 16'h3CC3, '1, '1));
      push_item(make_item(OP_QUERY, 24'h123456, 24'hABCDEF, 24'h00FF00,
                          '1, '1, '1, '1, '1, 23'd1, 23'd1));
      push_item(make_item(OP_UNUSED, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0));

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(76, 0, PHASE_ITEMS);
      run_phase(0, 76, PHASE_ITEMS);
      run_phase(10, 10, PHASE_ITEMS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
